>>> rtl/core/olist_pkg.sv
// ---------------------------------------------------------------------------
// olist_pkg
// Shared types and constants for the ordered list engine: slot and link
// widths, request and status codes, and the controller/datapath interface.
// ---------------------------------------------------------------------------
package olist_pkg;

  localparam int CAPACITY = 256;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int LINK_W   = SLOT_W + 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths of the request and result beats
  localparam int REQ_W  = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 9;
  localparam int STAT_W = 2;

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

  localparam logic [REQ_W-1:0] REQ_INS_POS = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_KEY = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DEL_POS = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_KEY = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FIND    = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

  // what the link registers capture ahead of a relink
  typedef enum logic [2:0] {
    LD_NONE,
    LD_TAIL,
    LD_POS,
    LD_KEY,
    LD_UNLINK
  } ld_t;

  typedef struct packed {
    logic              accept;
    logic              walk_adv;
    ld_t               ld;
    logic              link1;
    logic              link2;
    logic              unlink;
    logic              resp;
    logic [STAT_W-1:0] status;
    logic              found_en;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_ok;
    logic pos_hit;
    logic key_hit;
    logic last;
  } sts_t;

endpackage

>>> rtl/core/ordered_list_engine_unit.sv
// ---------------------------------------------------------------------------
// ordered_list_engine_unit
// Sequence: accept, decode, a walk where needed that follows one link per
//   cycle through the link RAMs, the LINK1 and LINK2 relink states for an
//   insert or the UNLINK state for a delete, then the result load, which
//   waits while the result register is still held by back-pressure.
// Takes a new request only once the previous one has loaded its result.
// Reset: synchronous, active low; the list comes up empty at once.
// ---------------------------------------------------------------------------
module ordered_list_engine_unit
  import olist_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [REQ_W-1:0]        in_req_type,
  input  logic signed [VAL_W-1:0] in_new_value,
  input  logic signed [VAL_W-1:0] in_search_key,
  input  logic [POS_W-1:0]        in_list_position,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STAT_W-1:0]       out_status,
  output logic [POS_W-1:0]        out_found_position,
  output logic [POS_W-1:0]        out_entry_count
);

  cmd_t cmd;
  sts_t sts;

  olist_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  olist_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_new_value       (in_new_value),
    .in_search_key      (in_search_key),
    .in_list_position   (in_list_position),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count)
  );

endmodule

>>> rtl/core/olist_ram.sv
// ---------------------------------------------------------------------------
// olist_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module olist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/olist_ctrl.sv
// ---------------------------------------------------------------------------
// olist_ctrl
// Request sequencer: decodes a request, steers the list walk, the relink
// steps and the result register.
// ---------------------------------------------------------------------------
module olist_ctrl
  import olist_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [REQ_W-1:0] in_req_type,
  output logic             out_valid,
  input  logic             out_ready,
  input  sts_t             sts,
  output cmd_t             cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_WALK   = 7'b0000100,
    S_LINK1  = 7'b0001000,
    S_LINK2  = 7'b0010000,
    S_UNLINK = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic              fnd_r, fnd_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              pos_mode;
  logic              hit;

  assign pos_mode  = (req_r == REQ_INS_POS) || (req_r == REQ_DEL_POS);
  assign hit       = pos_mode ? sts.pos_hit : sts.key_hit;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    stat_nxt      = stat_r;
    fnd_nxt       = fnd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.ld        = LD_NONE;
    cmd.status    = stat_r;
    cmd.found_en  = fnd_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          req_nxt    = in_req_type;
          stat_nxt   = ST_DONE;
          fnd_nxt    = 1'b0;
          state_nxt  = S_DECODE;
        end
      end

      S_DECODE: begin
        unique case (req_r)
          REQ_INS_POS: begin
            if (sts.full) begin
              stat_nxt  = ST_FULL;
              state_nxt = S_RESP;
            end else if (sts.pos_ok) begin
              state_nxt = S_WALK;
            end else begin
              cmd.ld    = LD_TAIL;
              state_nxt = S_LINK1;
            end
          end
          REQ_INS_KEY: begin
            if (sts.full) begin
              stat_nxt  = ST_FULL;
              state_nxt = S_RESP;
            end else if (sts.empty) begin
              cmd.ld    = LD_TAIL;
              state_nxt = S_LINK1;
            end else begin
              state_nxt = S_WALK;
            end
          end
          REQ_DEL_POS: begin
            if (sts.pos_ok) begin
              state_nxt = S_WALK;
            end else begin
              stat_nxt  = ST_MISS;
              state_nxt = S_RESP;
            end
          end
          REQ_DEL_KEY, REQ_FIND: begin
            if (sts.empty) begin
              stat_nxt  = ST_MISS;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_WALK;
            end
          end
          default: begin
            stat_nxt  = ST_MISS;
            state_nxt = S_RESP;
          end
        endcase
      end

      S_WALK: begin
        if (hit) begin
          unique case (req_r)
            REQ_INS_POS: begin
              cmd.ld    = LD_POS;
              state_nxt = S_LINK1;
            end
            REQ_INS_KEY: begin
              cmd.ld    = LD_KEY;
              state_nxt = S_LINK1;
            end
            REQ_DEL_POS, REQ_DEL_KEY: begin
              cmd.ld    = LD_UNLINK;
              state_nxt = S_UNLINK;
            end
            REQ_FIND: begin
              fnd_nxt   = 1'b1;
              state_nxt = S_RESP;
            end
            default: begin
              stat_nxt  = ST_MISS;
              state_nxt = S_RESP;
            end
          endcase
        end else if (!pos_mode && sts.last) begin
          // no match anywhere: insert after key falls back to the tail
          if (req_r == REQ_INS_KEY) begin
            cmd.ld    = LD_TAIL;
            state_nxt = S_LINK1;
          end else begin
            stat_nxt  = ST_MISS;
            state_nxt = S_RESP;
          end
        end else begin
          cmd.walk_adv = 1'b1;
        end
      end

      S_LINK1: begin
        cmd.link1 = 1'b1;
        state_nxt = S_LINK2;
      end

      S_LINK2: begin
        cmd.link2 = 1'b1;
        state_nxt = S_RESP;
      end

      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_nxt  = S_RESP;
      end

      S_RESP: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.resp      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      req_r       <= REQ_INS_POS;
      stat_r      <= ST_DONE;
      fnd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      req_r       <= req_nxt;
      stat_r      <= stat_nxt;
      fnd_r       <= fnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/olist_dp.sv
// ---------------------------------------------------------------------------
// olist_dp
// List datapath: value and link memories, free slot stack, head, tail and
// count registers, walk cursor and the result register.
// ---------------------------------------------------------------------------
module olist_dp
  import olist_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic signed [VAL_W-1:0]  in_new_value,
  input  logic signed [VAL_W-1:0]  in_search_key,
  input  logic [POS_W-1:0]         in_list_position,
  output logic [STAT_W-1:0]        out_status,
  output logic [POS_W-1:0]         out_found_position,
  output logic [POS_W-1:0]         out_entry_count
);

  logic [VAL_W-1:0]  val_r, key_r;
  logic [POS_W-1:0]  pos_r;
  logic [LINK_W-1:0] cur_r, a_r, nx_r;
  logic [CNT_W-1:0]  i_r;
  logic [SLOT_W-1:0] n_r;
  logic [LINK_W-1:0] head_r, tail_r;
  logic [CNT_W-1:0]  cnt_r, sp_r, fc_r;
  logic [STAT_W-1:0] status_o_r;
  logic [POS_W-1:0]  found_o_r, count_o_r;

  logic [SLOT_W-1:0] rd_addr;
  logic [VAL_W-1:0]  value_q;
  logic [LINK_W-1:0] next_q, prev_q;
  logic [SLOT_W-1:0] free_q;
  logic [SLOT_W-1:0] new_slot;
  logic [LINK_W-1:0] new_link;
  logic              a_ok, nx_ok;

  logic              nl_we, pl_we;
  logic [SLOT_W-1:0] nl_waddr, pl_waddr;
  logic [LINK_W-1:0] nl_wdata, pl_wdata;

  logic [CMP_W-1:0]  pos_ext, cnt_ext, i_ext;

  assign pos_ext = CMP_W'(pos_r);
  assign cnt_ext = CMP_W'(cnt_r);
  assign i_ext   = CMP_W'(i_r);

  assign sts.full    = (cnt_r == CNT_W'(CAPACITY));
  assign sts.empty   = (cnt_r == '0);
  assign sts.pos_ok  = (pos_r != '0) && (pos_ext <= cnt_ext);
  assign sts.pos_hit = (i_ext == pos_ext);
  assign sts.key_hit = (value_q == key_r);
  assign sts.last    = (i_r == cnt_r);

  // follow the link straight out of the read register while walking
  assign rd_addr = cmd.walk_adv ? next_q[SLOT_W-1:0] : cur_r[SLOT_W-1:0];

  // reuse a freed slot first, otherwise take the next untouched one
  assign new_slot = (sp_r != '0) ? free_q : fc_r[SLOT_W-1:0];
  assign new_link = LINK_W'(n_r);
  assign a_ok     = (a_r != NULL_LINK);
  assign nx_ok    = (nx_r != NULL_LINK);

  always_comb begin
    nl_we    = 1'b0;
    nl_waddr = a_r[SLOT_W-1:0];
    nl_wdata = nx_r;
    pl_we    = 1'b0;
    pl_waddr = nx_r[SLOT_W-1:0];
    pl_wdata = a_r;
    if (cmd.link1) begin
      nl_we    = 1'b1;
      nl_waddr = new_slot;
      pl_we    = 1'b1;
      pl_waddr = new_slot;
    end else if (cmd.link2) begin
      nl_we    = a_ok;
      nl_wdata = new_link;
      pl_we    = nx_ok;
      pl_wdata = new_link;
    end else if (cmd.unlink) begin
      nl_we = a_ok;
      pl_we = nx_ok;
    end
  end

  olist_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_value_ram (
    .clk   (clk),
    .we    (cmd.link1),
    .waddr (new_slot),
    .wdata (val_r),
    .raddr (rd_addr),
    .rdata (value_q)
  );

  olist_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (nl_we),
    .waddr (nl_waddr),
    .wdata (nl_wdata),
    .raddr (rd_addr),
    .rdata (next_q)
  );

  olist_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_prev_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (pl_wdata),
    .raddr (rd_addr),
    .rdata (prev_q)
  );

  olist_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free_ram (
    .clk   (clk),
    .we    (cmd.unlink),
    .waddr (sp_r[SLOT_W-1:0]),
    .wdata (cur_r[SLOT_W-1:0]),
    .raddr (SLOT_W'(sp_r - CNT_W'(1))),
    .rdata (free_q)
  );

  // request fields, cursor and link scratch registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_r <= in_new_value;
      key_r <= in_search_key;
      pos_r <= in_list_position;
      cur_r <= head_r;
      i_r   <= CNT_W'(1);
    end else if (cmd.walk_adv) begin
      cur_r <= next_q;
      i_r   <= i_r + CNT_W'(1);
    end

    unique case (cmd.ld)
      LD_NONE: begin
      end
      LD_TAIL: begin
        a_r  <= tail_r;
        nx_r <= NULL_LINK;
      end
      LD_POS: begin
        a_r  <= prev_q;
        nx_r <= cur_r;
      end
      LD_KEY: begin
        a_r  <= cur_r;
        nx_r <= next_q;
      end
      LD_UNLINK: begin
        a_r  <= prev_q;
        nx_r <= next_q;
      end
    endcase

    if (cmd.link1) begin
      n_r <= new_slot;
    end

    if (cmd.resp) begin
      status_o_r <= cmd.status;
      found_o_r  <= cmd.found_en ? POS_W'(i_r) : '0;
      count_o_r  <= POS_W'(cnt_r);
    end
  end

  // list ends, count and slot allocation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NULL_LINK;
      tail_r <= NULL_LINK;
      cnt_r  <= '0;
      sp_r   <= '0;
      fc_r   <= '0;
    end else if (cmd.link2) begin
      if (!a_ok) begin
        head_r <= new_link;
      end
      if (!nx_ok) begin
        tail_r <= new_link;
      end
      cnt_r <= cnt_r + CNT_W'(1);
      if (sp_r != '0) begin
        sp_r <= sp_r - CNT_W'(1);
      end else begin
        fc_r <= fc_r + CNT_W'(1);
      end
    end else if (cmd.unlink) begin
      if (!a_ok) begin
        head_r <= nx_r;
      end
      if (!nx_ok) begin
        tail_r <= a_r;
      end
      cnt_r <= cnt_r - CNT_W'(1);
      sp_r  <= sp_r + CNT_W'(1);
    end
  end

  assign out_status         = status_o_r;
  assign out_found_position = found_o_r;
  assign out_entry_count    = count_o_r;

endmodule

>>> test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for ordered_list_engine_unit. A queue-based image of
// the list predicts status, match position and entry count for each beat
// accepted on the request channel; replies are checked in order. Runs a
// directed pass over edge cases, fills the list to capacity and drains it
// to 16 entries, then a random mix, with random idling on both channels.
// ---------------------------------------------------------------------------
module tb_top
  import olist_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  found;
    logic [POS_W-1:0]  count;
  } list_reply_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [REQ_W-1:0]        in_req_type = '0;
  logic signed [VAL_W-1:0] in_new_value = '0;
  logic signed [VAL_W-1:0] in_search_key = '0;
  logic [POS_W-1:0]        in_list_position = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [STAT_W-1:0]       out_status;
  logic [POS_W-1:0]        out_found_position;
  logic [POS_W-1:0]        out_entry_count;

  logic signed [VAL_W-1:0] list_image[$];
  list_reply_t             reply_q[$];
  bit                      quiet = 1'b0;
  int                      error_count = 0;
  int                      replies_checked = 0;
  int                      peak_len = 0;
  int                      full_refusals = 0;
  int                      kind_seen[8] = '{default: 0};

  ordered_list_engine_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_new_value      (in_new_value),
    .in_search_key     (in_search_key),
    .in_list_position  (in_list_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_found_position(out_found_position),
    .out_entry_count   (out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 36);
  end

  function automatic void flag_error(string what);
    error_count++;
    if (error_count <= 10) $display("%0t ERROR %s", $time, what);
  endfunction

  // Apply one request to the list image and return the reply it must give.
  function automatic list_reply_t apply_request(logic [REQ_W-1:0] kind,
                                                logic signed [VAL_W-1:0] value,
                                                logic signed [VAL_W-1:0] key,
                                                logic [POS_W-1:0] pos);
    list_reply_t r;
    int          hit;
    int          n;
    r.status = ST_DONE;
    r.found  = '0;
    n   = list_image.size();
    hit = -1;
    for (int i = 0; i < n && hit < 0; i++)
      if (list_image[i] == key) hit = i;
    case (kind)
      REQ_INS_POS: begin
        if (n >= CAPACITY) begin
          r.status = ST_FULL;
          full_refusals++;
        end else if (pos >= 1 && pos <= n) begin
          list_image.insert(int'(pos) - 1, value);
        end else begin
          list_image.push_back(value);
        end
      end
      REQ_INS_KEY: begin
        if (n >= CAPACITY) begin
          r.status = ST_FULL;
          full_refusals++;
        end else if (hit >= 0) begin
          list_image.insert(hit + 1, value);
        end else begin
          list_image.push_back(value);
        end
      end
      REQ_DEL_POS: begin
        if (pos >= 1 && pos <= n) list_image.delete(int'(pos) - 1);
        else r.status = ST_MISS;
      end
      REQ_DEL_KEY: begin
        if (hit >= 0) list_image.delete(hit);
        else r.status = ST_MISS;
      end
      REQ_FIND: begin
        if (hit >= 0) r.found = POS_W'(hit + 1);
        else r.status = ST_MISS;
      end
      default: r.status = ST_MISS;
    endcase
    r.count = POS_W'(list_image.size());
    if (list_image.size() > peak_len) peak_len = list_image.size();
    return r;
  endfunction

  task automatic send_req(input logic [REQ_W-1:0] kind,
                          input logic signed [VAL_W-1:0] value,
                          input logic signed [VAL_W-1:0] key,
                          input logic [POS_W-1:0] pos);
    if (!quiet && $urandom_range(99) < 36) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_req_type      <= kind;
    in_new_value     <= value;
    in_search_key    <= key;
    in_list_position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    kind_seen[kind]++;
    reply_q.push_back(apply_request(kind, value, key, pos));
  endtask

  // Hold the request channel until every reply is back.
  task automatic wait_all_replies();
    @(negedge clk) in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return VAL_W'($signed($urandom_range(15)) - 8);
      5, 6, 7:       return $urandom;
      8:             return 32'sh8000_0000;
      default:       return 32'sh7fff_ffff;
    endcase
  endfunction

  // Keys mostly hit a live entry; positions mostly fall inside the list.
  task automatic send_random(input int ins_pct, input int del_pct, output bit useful);
    logic [REQ_W-1:0]        kind;
    logic signed [VAL_W-1:0] key;
    logic [POS_W-1:0]        pos;
    int                      n;
    int                      roll;
    n    = list_image.size();
    roll = $urandom_range(99);
    if ($urandom_range(39) == 0) kind = REQ_W'(5 + $urandom_range(2));
    else if (roll < ins_pct) kind = $urandom_range(1) ? REQ_INS_KEY : REQ_INS_POS;
    else if (roll < ins_pct + del_pct) kind = $urandom_range(1) ? REQ_DEL_KEY : REQ_DEL_POS;
    else kind = REQ_FIND;
    key = (n > 0 && $urandom_range(3) != 0) ? list_image[$urandom_range(n - 1)]
                                             : pick_value();
    pos = ($urandom_range(9) == 0) ? POS_W'($urandom_range(511))
                                   : POS_W'($urandom_range(n + 1));
    useful = (kind <= REQ_FIND);
    send_req(kind, pick_value(), key, pos);
  endtask

  task automatic test_directed_edges();
    send_req(REQ_FIND,    0, 0, 0);
    send_req(REQ_DEL_POS, 0, 0, 1);
    send_req(REQ_DEL_KEY, 0, 5, 0);
    send_req(REQ_INS_KEY, 32'sh7fff_ffff, 1, 0);
    send_req(REQ_INS_POS, 32'sh8000_0000, 0, 0);
    send_req(REQ_INS_POS, -1, 0, 1);
    send_req(REQ_INS_POS, 0, 0, 511);
    send_req(REQ_INS_POS, 42, 0, 4);
    send_req(REQ_INS_KEY, 7, 32'sh8000_0000, 0);
    send_req(REQ_INS_KEY, 9, 0, 0);
    send_req(REQ_INS_POS, 7, 0, 1);
    send_req(REQ_INS_KEY, 3, 7, 0);
    send_req(REQ_FIND,    0, 7, 0);
    send_req(REQ_FIND,    0, -1, 0);
    send_req(REQ_FIND,    0, 9, 0);
    send_req(REQ_FIND,    0, 12345, 0);
    send_req(REQ_DEL_POS, 0, 0, 0);
    send_req(REQ_DEL_POS, 0, 0, POS_W'(list_image.size() + 1));
    send_req(REQ_DEL_POS, 0, 0, 511);
    send_req(REQ_DEL_POS, 0, 0, 1);
    send_req(REQ_DEL_POS, 0, 0, POS_W'(list_image.size()));
    send_req(REQ_DEL_KEY, 0, 32'sh7fff_ffff, 0);
    send_req(REQ_DEL_KEY, 0, 32'sh7fff_ffff, 0);
    for (int k = 5; k < 8; k++) send_req(REQ_W'(k), -1, -1, 511);
    wait_all_replies();
  endtask

  task automatic test_fill_and_drain();
    bit useful;
    while (list_image.size() < CAPACITY) send_random(100, 0, useful);
    send_req(REQ_INS_POS, $urandom, 0, 1);
    send_req(REQ_INS_KEY, -5, list_image[0], 0);
    send_req(REQ_FIND,    0, list_image[CAPACITY - 1], 0);
    send_req(REQ_DEL_POS, 0, 0, POS_W'(CAPACITY));
    send_req(REQ_INS_POS, 32'sh8000_0000, 0, POS_W'(CAPACITY));
    send_req(REQ_INS_KEY, 32'sh7fff_ffff, 32'sh8000_0000, 0);
    while (list_image.size() > 16) send_random(5, 80, useful);
    wait_all_replies();
  endtask

  task automatic test_random_mix(input int items);
    bit useful;
    int done;
    done  = 0;
    quiet = 1'b1;
    while (done < items) begin
      // Let idling back in after a clean stretch.
      if (done == items / 3) quiet = 1'b0;
      if (list_image.size() > 40) send_random(25, 40, useful);
      else send_random(40, 35, useful);
      if (useful) done++;
    end
  endtask

  always @(posedge clk) begin : check_replies
    list_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        flag_error($sformatf("reply with nothing pending: status %0d found %0d count %0d",
                             out_status, out_found_position, out_entry_count));
      end else begin
        want = reply_q.pop_front();
        replies_checked++;
        if (out_status !== want.status)
          flag_error($sformatf("status: expected %0d, got %0d", want.status, out_status));
        if (out_found_position !== want.found)
          flag_error($sformatf("found position: expected %0d, got %0d",
                               want.found, out_found_position));
        if (out_entry_count !== want.count)
          flag_error($sformatf("entry count: expected %0d, got %0d",
                               want.count, out_entry_count));
      end
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_fill_and_drain();
    test_random_mix(160);
    wait_all_replies();
    repeat (CAPACITY + 16) @(posedge clk);
    if (reply_q.size() != 0) flag_error($sformatf("%0d replies never came", reply_q.size()));
    $display("requests: %0d insert-at, %0d insert-after, %0d delete-at, %0d delete-key,",
             kind_seen[REQ_INS_POS], kind_seen[REQ_INS_KEY], kind_seen[REQ_DEL_POS],
             kind_seen[REQ_DEL_KEY]);
    $display("  %0d find, %0d unknown; peak length %0d, %0d full refusals, %0d replies, %0d errors",
             kind_seen[REQ_FIND], kind_seen[5] + kind_seen[6] + kind_seen[7], peak_len,
             full_refusals, replies_checked, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Backstop: several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
